// File: sv/shfe_pkg.sv
// Shared types, constants and register codes of the SIP header field extractor.
// No dependencies; every other file of the block but shfe_checker uses this package.
package shfe_pkg;

  localparam int unsigned MAX_NAME_BYTES_DEF   = 16;
  localparam int unsigned VALUE_COUNT_BITS_DEF = 12;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAME_LO   = 3'd0,
    CFG_NAME_HI   = 3'd1,
    CFG_NAME_LEN  = 3'd2,
    CFG_INSTANCE  = 3'd3,
    CFG_MAX_VALUE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_COPY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [4:0]  name_length;
    logic [15:0] wanted_instance;
    logic [11:0] max_value_bytes;
  } cfg_t;

  // Occurrence report of the name window for the current byte
  typedef struct packed {
    logic at_resume;  // name+colon starts exactly at the resume point
    logic fresh;      // name+colon found past the resume point
    logic prev_eol;   // byte before the occurrence is CR or LF
  } occur_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       search_done;
    logic       field_found;
  } result_t;

endpackage

// File: sv/shfe_cfg_regs.sv
// Configuration register file of the SIP header field extractor.
// Depends on shfe_pkg for the register codes and the cfg_t bundle.
module shfe_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [shfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [shfe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output shfe_pkg::cfg_t                   cfg_o
);

  shfe_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_lo         <= '0;
      cfg_q.name_hi         <= '0;
      cfg_q.name_length     <= '0;
      cfg_q.wanted_instance <= '0;
      cfg_q.max_value_bytes <= 12'd255;
    end else if (cfg_we_i) begin
      case (shfe_pkg::cfg_idx_e'(cfg_idx_i))
        shfe_pkg::CFG_NAME_LO:   cfg_q.name_lo         <= cfg_wdata_i;
        shfe_pkg::CFG_NAME_HI:   cfg_q.name_hi         <= cfg_wdata_i;
        shfe_pkg::CFG_NAME_LEN:  cfg_q.name_length     <= cfg_wdata_i[4:0];
        shfe_pkg::CFG_INSTANCE:  cfg_q.wanted_instance <= cfg_wdata_i[15:0];
        shfe_pkg::CFG_MAX_VALUE: cfg_q.max_value_bytes <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/shfe_window.sv
// Sliding byte window and parallel name+colon compare of the field extractor.
// Depends on shfe_pkg; reports occurrences as an occur_t bundle.
module shfe_window #(
  parameter int unsigned MAX_NAME_BYTES = shfe_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_en_i,
  input  logic             clear_i,
  input  logic [7:0]       byte_i,
  input  shfe_pkg::cfg_t   cfg_i,
  output shfe_pkg::occur_t occ_o
);

  localparam int unsigned DEPTH  = MAX_NAME_BYTES + 1;  // stored bytes
  localparam int unsigned WIDTH  = MAX_NAME_BYTES + 2;  // bytes after the shift
  localparam int unsigned NLEN_W = $clog2(MAX_NAME_BYTES + 2);

  logic [7:0]        win_q [DEPTH];
  logic [7:0]        win_w [WIDTH];
  logic [7:0]        name_b [16];
  logic [4:0]        bsr_q, bsr_d, bsr_inc;
  logic [NLEN_W-1:0] nlen, plen;
  logic [MAX_NAME_BYTES:1] eq;
  logic              hit, ge_plen, eq_plen;
  logic [7:0]        prev;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      name_b[k]     = cfg_i.name_lo[8*k +: 8];
      name_b[k + 8] = cfg_i.name_hi[8*k +: 8];
    end
  end

  // Clamp the configured length to the window size
  assign nlen = (cfg_i.name_length > 5'(MAX_NAME_BYTES)) ? NLEN_W'(MAX_NAME_BYTES)
                                                         : cfg_i.name_length[NLEN_W-1:0];
  assign plen = nlen + NLEN_W'(1);

  always_comb begin
    win_w[0] = byte_i;
    for (int k = 1; k < WIDTH; k++) begin
      win_w[k] = win_q[k-1];
    end
  end

  // Position j of the window holds name byte nlen-j; the colon sits at position 0
  always_comb begin
    for (int j = 1; j <= MAX_NAME_BYTES; j++) begin
      eq[j] = (j > int'(nlen)) || (win_w[j] == name_b[4'(int'(nlen) - j)]);
    end
  end

  assign hit     = (win_w[0] == shfe_pkg::CH_COLON) && (&eq);
  assign bsr_inc = (bsr_q == 5'd31) ? bsr_q : bsr_q + 5'd1;
  assign ge_plen = bsr_inc >= 5'(plen);
  assign eq_plen = bsr_inc == 5'(plen);
  assign prev    = win_w[plen];

  assign occ_o.at_resume = hit && eq_plen;
  assign occ_o.fresh     = hit && ge_plen && !eq_plen;
  assign occ_o.prev_eol  = (prev == shfe_pkg::CH_LF) || (prev == shfe_pkg::CH_CR);

  // Restart the count after each occurrence passed over
  assign bsr_d = occ_o.fresh ? 5'd0 : bsr_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsr_q <= '0;
      for (int k = 0; k < DEPTH; k++) win_q[k] <= '0;
    end else if (clear_i) begin
      bsr_q <= '0;
      for (int k = 0; k < DEPTH; k++) win_q[k] <= '0;
    end else if (shift_en_i) begin
      bsr_q <= bsr_d;
      for (int k = 0; k < DEPTH; k++) win_q[k] <= win_w[k];
    end
  end

endmodule

// File: sv/shfe_ctrl.sv
// Phase control, instance and value counters of the field extractor.
// Depends on shfe_pkg; consumes the window's occur_t and forms a result_t.
module shfe_ctrl #(
  parameter int unsigned VALUE_COUNT_BITS = shfe_pkg::VALUE_COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  shfe_pkg::occur_t  occ_i,
  input  shfe_pkg::cfg_t    cfg_i,
  output logic              shift_en_o,
  output logic              clear_o,
  output logic              emit_o,
  output shfe_pkg::result_t res_o
);

  localparam int unsigned LIM_W = (VALUE_COUNT_BITS > 12) ? VALUE_COUNT_BITS : 12;
  localparam logic [LIM_W-1:0] CMASK = LIM_W'((33'd1 << VALUE_COUNT_BITS) - 33'd1);

  shfe_pkg::phase_e phase_q, phase_d;
  logic [15:0]      inst_q, inst_d;
  logic [VALUE_COUNT_BITS-1:0] copied_q, copied_d, copied_inc;
  logic [LIM_W-1:0] mvb, limit;
  logic             done, found, vvalid, shift, eol, blank;

  assign mvb        = LIM_W'(cfg_i.max_value_bytes);
  assign limit      = (mvb < CMASK) ? mvb : CMASK;
  assign copied_inc = copied_q + VALUE_COUNT_BITS'(1);
  assign eol   = (byte_i == shfe_pkg::CH_NUL) || (byte_i == shfe_pkg::CH_LF)
              || (byte_i == shfe_pkg::CH_CR);
  assign blank = (byte_i == shfe_pkg::CH_SPACE) || (byte_i == shfe_pkg::CH_TAB);

  always_comb begin
    phase_d  = phase_q;
    inst_d   = inst_q;
    copied_d = copied_q;
    done     = 1'b0;
    found    = 1'b0;
    vvalid   = 1'b0;
    shift    = 1'b0;
    case (phase_q)
      shfe_pkg::PH_SEARCH: begin
        if (byte_i == shfe_pkg::CH_NUL) begin
          done = 1'b1;
        end else begin
          shift = 1'b1;
          if (occ_i.at_resume) begin
            done = 1'b1;
          end else if (occ_i.fresh && occ_i.prev_eol) begin
            if (inst_q == cfg_i.wanted_instance) begin
              if (limit == '0) begin
                done  = 1'b1;
                found = 1'b1;
              end else begin
                phase_d = shfe_pkg::PH_SKIP;
              end
            end else begin
              inst_d = inst_q + 16'd1;
            end
          end
          // Message end: found only if the wanted field was just reached
          if (!done && last_i) begin
            done  = 1'b1;
            found = (phase_d != shfe_pkg::PH_SEARCH);
          end
        end
      end
      shfe_pkg::PH_SKIP, shfe_pkg::PH_COPY: begin
        if (eol) begin
          done  = 1'b1;
          found = 1'b1;
        end else if (phase_q == shfe_pkg::PH_SKIP && blank) begin
          if (last_i) begin
            done  = 1'b1;
            found = 1'b1;
          end
        end else begin
          phase_d  = shfe_pkg::PH_COPY;
          vvalid   = 1'b1;
          copied_d = copied_inc;
          if ((LIM_W'(copied_inc) >= limit) || last_i) begin
            done  = 1'b1;
            found = 1'b1;
          end
        end
      end
      shfe_pkg::PH_DONE: ;
      default: ;
    endcase
    if (done) phase_d = shfe_pkg::PH_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= shfe_pkg::PH_SEARCH;
      inst_q   <= '0;
      copied_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q  <= shfe_pkg::PH_SEARCH;
        inst_q   <= '0;
        copied_q <= '0;
      end else begin
        phase_q  <= phase_d;
        inst_q   <= inst_d;
        copied_q <= copied_d;
      end
    end
  end

  assign shift_en_o        = step_i && shift;
  assign clear_o           = step_i && last_i;
  assign emit_o            = vvalid || done;
  assign res_o.value_byte  = vvalid ? byte_i : 8'h00;
  assign res_o.value_valid = vvalid;
  assign res_o.search_done = done;
  assign res_o.field_found = done && found;

endmodule

// File: sv/sip_header_field_extractor_core.sv
// SIP header field extractor: input word register, window/phase logic, result register.
// A word accepted into the input word register shows its result at m_axis_tvalid from the result register.
// Throughput: one word per cycle; the result register stalls the input only when it is
// full, not taken, and the current word yields a result.
// Reset: rst_ni clears at once the stages, window, counters and registers (limit 255).
// Depends on shfe_pkg, shfe_cfg_regs, shfe_window and shfe_ctrl.
module sip_header_field_extractor_core #(
  parameter int unsigned MAX_NAME_BYTES   = shfe_pkg::MAX_NAME_BYTES_DEF,
  parameter int unsigned VALUE_COUNT_BITS = shfe_pkg::VALUE_COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] message_byte
  input  logic                            s_axis_tlast,   // end_of_message
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] value_byte
  output logic                            m_axis_tlast,   // search_done
  output logic [1:0]                      m_axis_tuser,   // [0] value_valid, [1] field_found
  input  logic                            cfg_we_i,
  input  logic [shfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [shfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  shfe_pkg::cfg_t    cfg;
  shfe_pkg::occur_t  occ;
  shfe_pkg::result_t res, out_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_valid_q;
  logic              emit, advance, shift_en, clear, accept;

  shfe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  shfe_window #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (shift_en),
    .clear_i    (clear),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg),
    .occ_o      (occ)
  );

  shfe_ctrl #(
    .VALUE_COUNT_BITS (VALUE_COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .occ_i      (occ),
    .cfg_i      (cfg),
    .shift_en_o (shift_en),
    .clear_o    (clear),
    .emit_o     (emit),
    .res_o      (res)
  );

  // Process the held word unless it has a result and the result slot stays full
  assign advance       = in_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.value_byte;
  assign m_axis_tlast    = out_q.search_done;
  assign m_axis_tuser[0] = out_q.value_valid;
  assign m_axis_tuser[1] = out_q.field_found;

endmodule

// File: sv/shfe_checker.sv
// Port-level checks of the SIP header field extractor result stream.
// Depends only on the top level's ports; bound to sip_header_field_extractor_core.
module shfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // Hold no result on the edge after one seen in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Flag found only on the word that ends the search
  a_found_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("field_found without search_done");

  // A word that does not end the search must carry a value byte
  a_mid_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("empty word before search_done");

  // Drive zero data on a word without a value byte
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("nonzero data without value_valid");

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind sip_header_field_extractor_core shfe_checker u_shfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: sim/shfe_value_checker.sv
// Checker for the SIP header field extractor: watches the input, result and register ports,
// predicts each result word from its own copy of the search state and compares in order.
// Depends on shfe_pkg.
`timescale 1ns / 1ps
module shfe_value_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] message_byte
  input  logic                            s_axis_tlast,   // end_of_message
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [7:0]                      m_axis_tdata,   // [7:0] value_byte
  input  logic                            m_axis_tlast,   // search_done
  input  logic [1:0]                      m_axis_tuser,   // [0] value_valid, [1] field_found
  input  logic                            cfg_we_i,
  input  logic [shfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [shfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int unsigned WINDOW_DEPTH = shfe_pkg::MAX_NAME_BYTES_DEF + 2;

  logic [63:0] name_lo;
  logic [63:0] name_hi;
  logic [4:0]  name_len;
  logic [15:0] wanted;
  logic [11:0] value_limit;

  logic [7:0]  window_q [WINDOW_DEPTH];
  logic [4:0]  since_resume;
  logic [15:0] counted;
  shfe_pkg::phase_e phase;
  logic [11:0] copied;

  shfe_pkg::result_t expected_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic clear_message();
    for (int i = 0; i < WINDOW_DEPTH; i++) window_q[i] = 8'h00;
    since_resume = '0;
    counted      = '0;
    phase        = shfe_pkg::PH_SEARCH;
    copied       = '0;
  endtask

  // Byte k of the name followed by its colon
  function automatic logic [7:0] name_char(input int unsigned k, input int unsigned nlen);
    if (k >= nlen) return shfe_pkg::CH_COLON;
    if (k < 8) return name_lo[8*k +: 8];
    return name_hi[8*(k-8) +: 8];
  endfunction

  task automatic predict_value_word(input logic [7:0] b, input logic last);
    int unsigned nlen;
    int unsigned plen;
    logic        hit;
    shfe_pkg::result_t r;
    r    = '0;
    nlen = (name_len > shfe_pkg::MAX_NAME_BYTES_DEF) ? shfe_pkg::MAX_NAME_BYTES_DEF : name_len;
    plen = nlen + 1;
    case (phase)
      shfe_pkg::PH_SEARCH: begin
        if (b == shfe_pkg::CH_NUL) begin
          r.search_done = 1'b1;
        end else begin
          for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
          window_q[0] = b;
          if (since_resume < 31) since_resume++;
          hit = (since_resume >= plen);
          for (int k = 0; k < plen; k++) begin
            if (window_q[plen-1-k] != name_char(k, nlen)) hit = 1'b0;
          end
          if (hit) begin
            if (since_resume == plen) begin
              // occurrence starts right at the resume point
              r.search_done = 1'b1;
            end else begin
              since_resume = '0;
              if (window_q[plen] == shfe_pkg::CH_LF || window_q[plen] == shfe_pkg::CH_CR) begin
                if (counted == wanted) begin
                  if (value_limit == 0) begin
                    r.search_done = 1'b1;
                    r.field_found = 1'b1;
                  end else begin
                    phase = shfe_pkg::PH_SKIP;
                  end
                end else begin
                  counted++;
                end
              end
            end
          end
          if (!r.search_done && last) begin
            r.search_done = 1'b1;
            r.field_found = (phase != shfe_pkg::PH_SEARCH);
          end
        end
      end
      shfe_pkg::PH_SKIP, shfe_pkg::PH_COPY: begin
        if (b == shfe_pkg::CH_NUL || b == shfe_pkg::CH_LF || b == shfe_pkg::CH_CR) begin
          r.search_done = 1'b1;
          r.field_found = 1'b1;
        end else if (phase == shfe_pkg::PH_SKIP
                     && (b == shfe_pkg::CH_SPACE || b == shfe_pkg::CH_TAB)) begin
          if (last) begin
            r.search_done = 1'b1;
            r.field_found = 1'b1;
          end
        end else begin
          phase         = shfe_pkg::PH_COPY;
          r.value_valid = 1'b1;
          r.value_byte  = b;
          copied++;
          if (copied >= value_limit || last) begin
            r.search_done = 1'b1;
            r.field_found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (r.search_done) phase = shfe_pkg::PH_DONE;
    if (r.value_valid || r.search_done) expected_results.push_back(r);
    if (last) clear_message();
  endtask

  always @(posedge clk_i) begin : watch
    shfe_pkg::result_t got;
    shfe_pkg::result_t want;
    if (!rst_ni) begin
      name_lo     = '0;
      name_hi     = '0;
      name_len    = '0;
      wanted      = '0;
      value_limit = 12'd255;
      clear_message();
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          shfe_pkg::CFG_NAME_LO:   name_lo     = cfg_wdata_i;
          shfe_pkg::CFG_NAME_HI:   name_hi     = cfg_wdata_i;
          shfe_pkg::CFG_NAME_LEN:  name_len    = cfg_wdata_i[4:0];
          shfe_pkg::CFG_INSTANCE:  wanted      = cfg_wdata_i[15:0];
          shfe_pkg::CFG_MAX_VALUE: value_limit = cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_value_word(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.value_byte  = m_axis_tdata;
        got.value_valid = m_axis_tuser[0];
        got.search_done = m_axis_tlast;
        got.field_found = m_axis_tuser[1];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got byte %02h valid %0b",
                   $time, got.value_byte, got.value_valid,
                   " done %0b found %0b", got.search_done, got.field_found);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result word mismatch: expected byte %02h valid %0b done %0b",
                     $time, want.value_byte, want.value_valid, want.search_done,
                     " found %0b, got byte %02h valid %0b done %0b found %0b",
                     want.field_found, got.value_byte, got.value_valid,
                     got.search_done, got.field_found);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
// Top of the SIP header field extractor testbench: clock, reset, register setup and byte stimulus,
// random stalls on both streams; the verdict comes from shfe_value_checker.
// Depends on shfe_pkg, shfe_value_checker and sip_header_field_extractor_core.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = 8'h00;   // [7:0] message_byte
  logic                            s_axis_tlast  = 1'b0;    // end_of_message
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [7:0]                      m_axis_tdata;            // [7:0] value_byte
  logic                            m_axis_tlast;            // search_done
  logic [1:0]                      m_axis_tuser;            // [0] value_valid, [1] field_found
  logic                            cfg_we_i      = 1'b0;
  logic [shfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [shfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  int          fail_count;
  int          pending;
  logic        quiet     = 1'b0;
  logic        hold_req  = 1'b0;
  int          hold_left = 0;
  int          cycles    = 0;
  logic [7:0]  msg [$];
  logic [7:0]  name_b [shfe_pkg::MAX_NAME_BYTES_DEF];
  int unsigned name_n;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sip_header_field_extractor_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  shfe_value_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[sip_header_field_extractor_core] ERROR");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_word(msg[i], i == msg.size() - 1);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    msg.delete();
    push_str(s);
    send_msg();
  endtask

  // Drop valid, wait for every expected word, then let the pipeline run empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic cfg_write(input shfe_pkg::cfg_idx_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Load the current name (bytes past its length random) and both limits
  task automatic configure(input int unsigned inst, input int unsigned maxv);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int k = 0; k < name_n; k++) begin
      if (k < 8) lo[8*k +: 8] = name_b[k];
      else hi[8*(k-8) +: 8] = name_b[k];
    end
    cfg_write(shfe_pkg::CFG_NAME_LO, lo);
    cfg_write(shfe_pkg::CFG_NAME_HI, hi);
    cfg_write(shfe_pkg::CFG_NAME_LEN, 64'(name_n));
    cfg_write(shfe_pkg::CFG_INSTANCE, 64'(inst));
    cfg_write(shfe_pkg::CFG_MAX_VALUE, 64'(maxv));
  endtask

  task automatic random_name(input int unsigned len);
    name_n = len;
    for (int k = 0; k < len; k++) name_b[k] = 8'($urandom_range(8'h21, 8'h7e));
  endtask

  task automatic push_eol();
    case ($urandom_range(2))
      0: begin
        msg.push_back(shfe_pkg::CH_CR);
        msg.push_back(shfe_pkg::CH_LF);
      end
      1:       msg.push_back(shfe_pkg::CH_LF);
      default: msg.push_back(shfe_pkg::CH_CR);
    endcase
  endtask

  task automatic push_text(input int unsigned n);
    repeat (n) msg.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endtask

  task automatic push_name_colon();
    for (int k = 0; k < name_n; k++) msg.push_back(name_b[k]);
    msg.push_back(shfe_pkg::CH_COLON);
  endtask

  task automatic push_value();
    logic [7:0] v;
    repeat ($urandom_range(2)) begin
      msg.push_back($urandom_range(1) ? shfe_pkg::CH_SPACE : shfe_pkg::CH_TAB);
    end
    repeat ($urandom_range(8)) begin
      v = 8'($urandom_range(1, 255));
      if (v == shfe_pkg::CH_CR || v == shfe_pkg::CH_LF) v = 8'h41;
      msg.push_back(v);
    end
  endtask

  // Mostly header-like messages around the name; some raw noise
  task automatic build_random_msg();
    msg.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(19) == 0) push_name_colon();
    else push_text($urandom_range(1, 8));
    repeat ($urandom_range(1, 4)) begin
      push_eol();
      case ($urandom_range(5))
        0, 1, 2: begin
          push_name_colon();
          push_value();
        end
        3: begin
          push_text($urandom_range(1, 3));
          push_name_colon();
          push_value();
        end
        4: begin
          push_name_colon();
          push_name_colon();
          push_value();
        end
        default: push_text($urandom_range(1, 10));
      endcase
    end
    case ($urandom_range(3))
      0: ;
      1: push_eol();
      2: begin
        msg.push_back(shfe_pkg::CH_NUL);
        push_text($urandom_range(3));
      end
      default: begin
        push_eol();
        push_text($urandom_range(1, 4));
      end
    endcase
  endtask

  task automatic run_phase(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      build_random_msg();
      send_msg();
      sent += msg.size();
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: empty name, so a bare colon after a line break is the field
    send_text("\n:ab\r");
    settle();

    name_n    = 1;
    name_b[0] = "a";
    configure(0, 255);
    send_text("a:");
    send_text("\na:x");
    send_text("\na: \t\r");
    send_text("zz");
    msg.delete();
    push_str("z");
    msg.push_back(shfe_pkg::CH_NUL);
    send_msg();
    msg.delete();
    push_str("\na:");
    msg.push_back(8'h80);
    msg.push_back(8'hff);
    msg.push_back(shfe_pkg::CH_LF);
    push_str("q");
    send_msg();
    settle();

    configure(0, 0);
    send_text("\na:xy");
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          random_name($urandom_range(1, 4));
          configure(0, $urandom_range(1, 10));
        end
        1: begin
          random_name(shfe_pkg::MAX_NAME_BYTES_DEF);
          configure(1, 4095);
        end
        2: begin
          name_n = 0;
          configure(0, 3);
        end
        3: begin
          random_name(3);
          name_b[1] = shfe_pkg::CH_NUL;
          configure(0, 255);
        end
        4: begin
          random_name($urandom_range(1, shfe_pkg::MAX_NAME_BYTES_DEF));
          configure($urandom_range(2), 0);
        end
        5: begin
          random_name($urandom_range(1, shfe_pkg::MAX_NAME_BYTES_DEF));
          configure(16'hFFFF, $urandom_range(1, 20));
        end
        6: begin
          random_name($urandom_range(1, 3));
          configure(2, 1);
        end
        default: begin
          random_name($urandom_range(1, 6));
          configure($urandom_range(3), $urandom_range(1, 12));
        end
      endcase
      if (p == 2) hold_req = 1'b1;
      quiet = (p == 4);
      run_phase(75);
    end
    quiet = 1'b0;

    if (fail_count == 0) begin
      $display("[sip_header_field_extractor_core] OK");
    end else begin
      $display("[sip_header_field_extractor_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/shfe_pkg.sv
sv/shfe_cfg_regs.sv
sv/shfe_window.sv
sv/shfe_ctrl.sv
sv/sip_header_field_extractor_core.sv
sv/shfe_checker.sv
sim/shfe_value_checker.sv
sim/tb_top.sv
